// ===== src/bitmap_page_allocator_core_defines.svh =====
// Assertion helpers shared by the allocator RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bpa_pkg.sv =====
package bpa_pkg;

  localparam int MAP_WORDS    = 128;
  // MAX_RUN stays within WORD_BITS, so a run never spans more than two map words.
  localparam int MAX_RUN      = 32;
  localparam int WORD_BITS    = 32;
  localparam int PAGE_SHIFT   = 12;
  localparam int TOTAL_BLOCKS = MAP_WORDS * WORD_BITS;

  localparam int WADDR_W  = $clog2(MAP_WORDS);
  localparam int NWORDS_W = $clog2(MAP_WORDS + 1);
  localparam int BIT_W    = $clog2(WORD_BITS);
  localparam int BLK_W    = $clog2(TOTAL_BLOCKS);
  localparam int LIMIT_W  = 13;
  localparam int CNT_W    = 6;
  localparam int ADDR_W   = 32;
  localparam int IDX_W    = ADDR_W - PAGE_SHIFT;
  localparam int CFG_IDX_W = 1;

  localparam logic [LIMIT_W-1:0] BLOCK_LIMIT_RST = 13'd4096;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    scan;
    logic    mark_hi;
    logic    mark_lo;
    logic    free_rd;
    logic    free_lo;
    logic    free_hi;
    logic    post;
    status_t post_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic alloc_bad;
    logic free_zero;
    logic free_bad;
    logic found;
    logic exhausted;
    logic free_hi_need;
  } dp_stat_t;

endpackage

// ===== src/bitmap_page_allocator_core.sv =====
// Channel   Handshake          Word
// -------   ----------------   --------------------------------------
// request   start / busy       func, block_count, address
// result    done (one cycle)   status, block_address
// config    wr_en              wr_index, wr_data
//
// A request is taken when start is high and busy is low; one result follows.
// Allocate: scans the map with one map word read per cycle from the single
// read port of the map RAM, then marks the run; free: reads, then clears one
// or two words; a rejected request is answered from the decode state.
// Reset clears the per-word valid flags at once, so the map reads all free
// on the first cycle after reset; no clearing sweep.
// done is a one-cycle strobe; the receiver cannot stall it.
module bitmap_page_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [bpa_pkg::CNT_W-1:0]     block_count,
  input  logic [bpa_pkg::ADDR_W-1:0]    address,
  input  logic                          wr_en,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [bpa_pkg::ADDR_W-1:0]    wr_data,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [bpa_pkg::ADDR_W-1:0]    block_address
);

  bpa_pkg::ctrl_cmd_t cmd;
  bpa_pkg::dp_stat_t  st;

  bpa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .st   (st),
    .cmd  (cmd)
  );

  bpa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .func         (func),
    .block_count  (block_count),
    .address      (address),
    .done         (done),
    .status       (status),
    .block_address(block_address)
  );

endmodule

// ===== src/bpa_ram.sv =====
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bpa_ctrl.sv =====
`include "bitmap_page_allocator_core_defines.svh"

module bpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bpa_pkg::dp_stat_t   st,
  output bpa_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_SCAN    = 8'b0000_0100,
    S_MARK_HI = 8'b0000_1000,
    S_MARK_LO = 8'b0001_0000,
    S_FREE_RD = 8'b0010_0000,
    S_FREE_LO = 8'b0100_0000,
    S_FREE_HI = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.post_status = bpa_pkg::ST_DONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_alloc) begin
          if (st.alloc_bad) begin
            cmd.post        = 1'b1;
            cmd.post_status = bpa_pkg::ST_NO_SPACE;
            state_next      = S_IDLE;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end else if (st.free_zero) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end else if (st.free_bad) begin
          cmd.post        = 1'b1;
          cmd.post_status = bpa_pkg::ST_RANGE;
          state_next      = S_IDLE;
        end else begin
          state_next = S_FREE_RD;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.found) begin
          state_next = S_MARK_HI;
        end else if (st.exhausted) begin
          cmd.post        = 1'b1;
          cmd.post_status = bpa_pkg::ST_NO_SPACE;
          state_next      = S_IDLE;
        end
      end
      S_MARK_HI: begin
        cmd.mark_hi = 1'b1;
        state_next  = S_MARK_LO;
      end
      S_MARK_LO: begin
        cmd.mark_lo = 1'b1;
        cmd.post    = 1'b1;
        state_next  = S_IDLE;
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_next  = S_FREE_LO;
      end
      S_FREE_LO: begin
        cmd.free_lo = 1'b1;
        if (st.free_hi_need) begin
          state_next = S_FREE_HI;
        end else begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FREE_HI: begin
        cmd.free_hi = 1'b1;
        cmd.post    = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BPA_ASSERT_NXT(a_post_to_idle, cmd.post, state == S_IDLE, "result posted without return to idle")
  `BPA_ASSERT_IMP(a_scan_excl, state == S_SCAN && st.found, !st.exhausted, "scan hit and exhausted together")
  `BPA_ASSERT_IMP(a_alloc_path, state == S_SCAN || state == S_MARK_HI || state == S_MARK_LO, st.is_alloc, "allocate states entered on a free")
  `BPA_ASSERT_IMP(a_free_path, state == S_FREE_RD || state == S_FREE_LO || state == S_FREE_HI, !st.is_alloc && !st.free_bad && !st.free_zero, "free states entered on a rejected request")

endmodule

// ===== src/bpa_dp.sv =====
`include "bitmap_page_allocator_core_defines.svh"

module bpa_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bpa_pkg::ctrl_cmd_t                     cmd,
  output bpa_pkg::dp_stat_t                      st,
  input  logic                                   wr_en,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]          wr_index,
  input  logic [bpa_pkg::ADDR_W-1:0]             wr_data,
  input  logic                                   func,
  input  logic [bpa_pkg::CNT_W-1:0]              block_count,
  input  logic [bpa_pkg::ADDR_W-1:0]             address,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [bpa_pkg::ADDR_W-1:0]             block_address
);

  localparam logic [bpa_pkg::WORD_BITS-1:0] ONES = '1;

  // Configuration
  logic [bpa_pkg::LIMIT_W-1:0]  block_limit;
  logic [bpa_pkg::ADDR_W-1:0]   region_base;
  logic [bpa_pkg::LIMIT_W-1:0]  lim;
  logic [bpa_pkg::NWORDS_W-1:0] nwords;
  logic [bpa_pkg::NWORDS_W-1:0] lim_w;
  logic [bpa_pkg::BIT_W-1:0]    lim_b;

  // Request
  logic                         req_alloc;
  logic [bpa_pkg::CNT_W-1:0]    cnt_raw;
  logic [bpa_pkg::CNT_W-1:0]    cnt;
  logic [bpa_pkg::ADDR_W:0]     off;
  logic [bpa_pkg::IDX_W-1:0]    idx;
  logic [bpa_pkg::WADDR_W-1:0]  fi;
  logic [bpa_pkg::BIT_W-1:0]    fbit;
  logic [bpa_pkg::WORD_BITS-1:0]   topmask;
  logic [bpa_pkg::WORD_BITS-1:0]   lowmask;
  logic [2*bpa_pkg::WORD_BITS-1:0] fmask;
  logic [2*bpa_pkg::WORD_BITS-1:0] amask;

  // Scan
  logic [bpa_pkg::NWORDS_W-1:0]  rd_w;
  logic                          ev_v;
  logic [bpa_pkg::WADDR_W-1:0]   ev_w;
  logic                          scan_re;
  logic [bpa_pkg::WORD_BITS-1:0] prev_raw;
  logic [bpa_pkg::WORD_BITS-1:0] prev_eff;
  logic [bpa_pkg::WORD_BITS-1:0] cur_raw;
  logic [bpa_pkg::WORD_BITS-1:0] cur_lmask;
  logic [bpa_pkg::WORD_BITS-1:0] cur_eff;
  logic [2*bpa_pkg::WORD_BITS-1:0] win;
  logic [bpa_pkg::WORD_BITS-1:0] hitv;
  logic [bpa_pkg::BIT_W-1:0]     hit_b_c;
  logic [bpa_pkg::WADDR_W-1:0]   hit_w;
  logic [bpa_pkg::BIT_W-1:0]     hit_b;
  logic [bpa_pkg::WORD_BITS-1:0] lo_raw;
  logic [bpa_pkg::WORD_BITS-1:0] hi_raw;
  logic [bpa_pkg::BIT_W:0]       amt;
  logic [bpa_pkg::LIMIT_W-1:0]   start_c;
  logic [bpa_pkg::BLK_W-1:0]     start_blk;

  // Map memory
  logic                          ram_we;
  logic [bpa_pkg::WADDR_W-1:0]   ram_waddr;
  logic [bpa_pkg::WORD_BITS-1:0] ram_wdata;
  logic                          ram_re;
  logic [bpa_pkg::WADDR_W-1:0]   ram_raddr;
  logic [bpa_pkg::WORD_BITS-1:0] ram_q;
  logic [bpa_pkg::MAP_WORDS-1:0] wvalid;
  logic                          valid_q;

  bpa_pkg::status_t result_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_limit <= bpa_pkg::BLOCK_LIMIT_RST;
      region_base <= '0;
    end else if (wr_en) begin
      case (wr_index)
        bpa_pkg::CFG_BLOCK_LIMIT: block_limit <= wr_data[bpa_pkg::LIMIT_W-1:0];
        bpa_pkg::CFG_REGION_BASE: region_base <= wr_data;
        default: ;
      endcase
    end
  end

  assign lim = (block_limit < bpa_pkg::LIMIT_W'(bpa_pkg::TOTAL_BLOCKS)) ?
               block_limit : bpa_pkg::LIMIT_W'(bpa_pkg::TOTAL_BLOCKS);
  assign nwords = bpa_pkg::NWORDS_W'((lim + bpa_pkg::LIMIT_W'(bpa_pkg::WORD_BITS - 1))
                  >> bpa_pkg::BIT_W);
  assign lim_w = bpa_pkg::NWORDS_W'(lim >> bpa_pkg::BIT_W);
  assign lim_b = lim[bpa_pkg::BIT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_alloc <= (func == bpa_pkg::FUNC_ALLOC);
      cnt_raw   <= block_count;
      cnt       <= (block_count > bpa_pkg::CNT_W'(bpa_pkg::MAX_RUN)) ?
                   bpa_pkg::CNT_W'(bpa_pkg::MAX_RUN) : block_count;
      // borrow in the top bit flags an address below the region
      off       <= {1'b0, address} - {1'b0, region_base};
    end
  end

  assign idx  = off[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
  assign fi   = off[bpa_pkg::PAGE_SHIFT+bpa_pkg::BIT_W +: bpa_pkg::WADDR_W];
  assign fbit = off[bpa_pkg::PAGE_SHIFT +: bpa_pkg::BIT_W];

  assign topmask = ~(ONES >> cnt);
  assign lowmask = ~(ONES << cnt);
  assign fmask   = {bpa_pkg::WORD_BITS'(0), lowmask} << fbit;
  assign amt     = (bpa_pkg::BIT_W + 1)'(hit_b) + (bpa_pkg::BIT_W + 1)'(1);
  // run ends at bit hit_b of the upper word and may reach back into the lower one
  assign amask   = {bpa_pkg::WORD_BITS'(0), topmask} << amt;
  assign start_c = bpa_pkg::LIMIT_W'({hit_w, bpa_pkg::BIT_W'(0)}) +
                   bpa_pkg::LIMIT_W'(hit_b) + bpa_pkg::LIMIT_W'(1) -
                   bpa_pkg::LIMIT_W'(cnt);

  assign cur_raw   = valid_q ? ram_q : '0;
  assign cur_lmask = (bpa_pkg::NWORDS_W'(ev_w) < lim_w) ? '0 :
                     (bpa_pkg::NWORDS_W'(ev_w) == lim_w) ? (ONES << lim_b) : ONES;
  assign cur_eff   = cur_raw | cur_lmask;
  assign win       = {cur_eff, prev_eff};
  assign scan_re   = (rd_w < nwords);

  // A hit at bit b means the count bits ending there are all free.
  always_comb begin
    hitv = '0;
    for (int b = 0; b < bpa_pkg::WORD_BITS; b++) begin
      hitv[b] = ~|(win[b+bpa_pkg::WORD_BITS -: bpa_pkg::WORD_BITS] & topmask);
    end
  end

  always_comb begin
    hit_b_c = '0;
    for (int b = bpa_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (hitv[b]) begin
        hit_b_c = bpa_pkg::BIT_W'(b);
      end
    end
  end

  always_comb begin
    st.is_alloc     = req_alloc;
    st.alloc_bad    = (cnt_raw == '0) || (cnt_raw > bpa_pkg::CNT_W'(bpa_pkg::MAX_RUN)) ||
                      (lim == '0);
    st.free_zero    = (cnt == '0);
    st.free_bad     = off[bpa_pkg::ADDR_W] ||
                      (({1'b0, idx} + (bpa_pkg::IDX_W + 1)'(cnt)) >
                       (bpa_pkg::IDX_W + 1)'(lim));
    st.found        = ev_v && (|hitv);
    st.exhausted    = !ev_v && !scan_re;
    st.free_hi_need = |fmask[2*bpa_pkg::WORD_BITS-1:bpa_pkg::WORD_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_v <= 1'b0;
      rd_w <= '0;
    end else if (cmd.scan_init) begin
      ev_v <= 1'b0;
      rd_w <= '0;
    end else if (cmd.scan) begin
      ev_v <= scan_re;
      if (scan_re) begin
        rd_w <= rd_w + bpa_pkg::NWORDS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      // nothing precedes word zero: treat it as used
      prev_eff <= ONES;
      prev_raw <= '0;
    end else if (cmd.scan) begin
      ev_w <= rd_w[bpa_pkg::WADDR_W-1:0];
      if (ev_v) begin
        prev_raw <= cur_raw;
        prev_eff <= cur_eff;
      end
      if (st.found) begin
        hit_w  <= ev_w;
        hit_b  <= hit_b_c;
        lo_raw <= prev_raw;
        hi_raw <= cur_raw;
      end
    end
    if (cmd.mark_hi) begin
      start_blk <= start_c[bpa_pkg::BLK_W-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_w;
    ram_wdata = hi_raw | amask[2*bpa_pkg::WORD_BITS-1:bpa_pkg::WORD_BITS];
    ram_re    = 1'b0;
    ram_raddr = rd_w[bpa_pkg::WADDR_W-1:0];
    if (cmd.scan) begin
      ram_re = scan_re;
    end
    if (cmd.mark_hi) begin
      ram_we = 1'b1;
    end
    if (cmd.mark_lo) begin
      ram_we    = |amask[bpa_pkg::WORD_BITS-1:0];
      ram_waddr = hit_w - bpa_pkg::WADDR_W'(1);
      ram_wdata = lo_raw | amask[bpa_pkg::WORD_BITS-1:0];
    end
    if (cmd.free_rd) begin
      ram_re    = 1'b1;
      ram_raddr = fi;
    end
    if (cmd.free_lo) begin
      // clear the low word and fetch the next one in the same cycle
      ram_re    = 1'b1;
      ram_raddr = fi + bpa_pkg::WADDR_W'(1);
      ram_we    = 1'b1;
      ram_waddr = fi;
      ram_wdata = cur_raw & ~fmask[bpa_pkg::WORD_BITS-1:0];
    end
    if (cmd.free_hi) begin
      ram_we    = 1'b1;
      ram_waddr = fi + bpa_pkg::WADDR_W'(1);
      ram_wdata = cur_raw & ~fmask[2*bpa_pkg::WORD_BITS-1:bpa_pkg::WORD_BITS];
    end
  end

  bpa_ram #(
    .WIDTH(bpa_pkg::WORD_BITS),
    .DEPTH(bpa_pkg::MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // A map word never written reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (ram_we) begin
      wvalid[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      valid_q <= wvalid[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.post;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      result_status <= cmd.post_status;
      block_address <= (cmd.post_status == bpa_pkg::ST_DONE && req_alloc) ?
                       region_base + (bpa_pkg::ADDR_W'(start_blk) << bpa_pkg::PAGE_SHIFT) :
                       '0;
    end
  end

  assign status = result_status;

  `BPA_ASSERT_IMP(a_mark_hi_free, cmd.mark_hi, (hi_raw & amask[2*bpa_pkg::WORD_BITS-1:bpa_pkg::WORD_BITS]) == '0, "allocated run overlaps used blocks in upper word")
  `BPA_ASSERT_IMP(a_mark_lo_free, cmd.mark_lo, (lo_raw & amask[bpa_pkg::WORD_BITS-1:0]) == '0, "allocated run overlaps used blocks in lower word")
  `BPA_ASSERT_IMP(a_run_in_limit, cmd.mark_hi, (start_c + bpa_pkg::LIMIT_W'(cnt)) <= lim, "allocated run crosses the block limit")
  `BPA_ASSERT_IMP(a_fail_addr_zero, done && result_status != bpa_pkg::ST_DONE, block_address == '0, "failed request returned a nonzero address")

endmodule
